FILE: hw/rtl/dlr_pkg.sv
`default_nettype none

package dlr_pkg;

  // Fixed field widths
  localparam int COORD_W   = 6;
  localparam int RGBA_W    = 32;
  localparam int CFG_W     = 7;
  localparam int TILE_SIZE = 64;

  // Configuration register indexes (byte address = 4 * index)
  typedef enum logic {
    REG_RASTER_WIDTH  = 1'b0,
    REG_RASTER_HEIGHT = 1'b1
  } dlr_reg_t;

  // Controller to datapath
  typedef struct packed {
    logic load;  // capture a line command and start the slope division
    logic emit;  // register the current pixel and advance along the line
  } dlr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_done;  // final quotient bit is being produced this cycle
    logic at_end;    // major position has reached the far endpoint
    logic out_free;  // output register can take a pixel this cycle
  } dlr_status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/dlr_div.sv
`default_nettype none

// Restoring divider for (dividend << FRACTION_BITS) / divisor with
// dividend <= divisor, one quotient bit per cycle, most significant first.
module dlr_div #(
  parameter int FRACTION_BITS = 8
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [dlr_pkg::COORD_W-1:0] dividend,
  input  wire logic [dlr_pkg::COORD_W-1:0] divisor,
  output logic                            done,
  output logic [FRACTION_BITS:0]          quotient
);

  localparam int CNT_W = $clog2(FRACTION_BITS + 1);
  localparam int REM_W = dlr_pkg::COORD_W + 1;

  logic                          running;
  logic [CNT_W-1:0]              count;
  logic [REM_W-1:0]              rem;
  logic [dlr_pkg::COORD_W-1:0]   divisor_r;
  logic [FRACTION_BITS-1:0]      quot;
  logic                          step_bit;
  logic [dlr_pkg::COORD_W-1:0]   rem_diff;
  logic [dlr_pkg::COORD_W-1:0]   rem_keep;

  // One trial subtraction per cycle; a kept difference is below the divisor
  always_comb begin
    step_bit = (rem >= {1'b0, divisor_r});
    rem_diff = rem[dlr_pkg::COORD_W-1:0] - divisor_r;
    rem_keep = step_bit ? rem_diff : rem[dlr_pkg::COORD_W-1:0];
  end

  assign done     = running && (count == CNT_W'(FRACTION_BITS));
  assign quotient = {quot, step_bit};

  // Hold operands, shift the partial remainder, collect quotient bits
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      count   <= '0;
    end else if (start) begin
      running   <= 1'b1;
      count     <= '0;
      rem       <= {1'b0, dividend};
      divisor_r <= divisor;
    end else if (running) begin
      rem   <= {rem_keep, 1'b0};
      quot  <= {quot[FRACTION_BITS-2:0], step_bit};
      count <= count + CNT_W'(1);
      if (done) begin
        running <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  // Done lasts a single cycle per division
  a_done_once: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("divider done held for more than one cycle");
  // The partial remainder stays below twice the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (running && !start) |-> (rem <= {divisor_r, 1'b0}) || (divisor_r == '0))
    else $error("divider remainder out of range");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/dlr_datapath.sv
`default_nettype none

module dlr_datapath #(
  parameter int FRACTION_BITS = 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire dlr_pkg::dlr_cmd_t           cmd,
  output dlr_pkg::dlr_status_t             status,
  input  wire logic [dlr_pkg::CFG_W-1:0]   raster_width,
  input  wire logic [dlr_pkg::CFG_W-1:0]   raster_height,
  input  wire logic [dlr_pkg::COORD_W-1:0] start_x,
  input  wire logic [dlr_pkg::COORD_W-1:0] start_y,
  input  wire logic [dlr_pkg::COORD_W-1:0] end_x,
  input  wire logic [dlr_pkg::COORD_W-1:0] end_y,
  input  wire logic [dlr_pkg::RGBA_W-1:0]  line_rgba,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [dlr_pkg::COORD_W-1:0]      pixel_x,
  output logic [dlr_pkg::COORD_W-1:0]      pixel_y,
  output logic [dlr_pkg::RGBA_W-1:0]       pixel_rgba,
  output logic                             visible,
  output logic                             last_pixel
);

  localparam int CW      = dlr_pkg::COORD_W;
  localparam int SLOPE_W = FRACTION_BITS + 2;
  localparam int ACC_W   = CW + FRACTION_BITS + 1;
  localparam logic [CW-1:0] TILE_MAX = CW'(dlr_pkg::TILE_SIZE - 1);

  function automatic logic [CW-1:0] clamp_coord(input logic [CW-1:0] v);
    clamp_coord = (v > TILE_MAX) ? TILE_MAX : v;
  endfunction

  logic [CW-1:0] x1, y1, x2, y2;
  logic [CW:0]   dx, dy;
  logic [CW-1:0] abs_dx, abs_dy;
  logic          steep;
  logic [CW-1:0] maj1, min1, maj2, min2;
  logic [CW-1:0] abs_maj, abs_min;
  logic          neg_slope;
  logic          reversed;
  logic [CW-1:0] maj_start, min_start, maj_stop;

  // Line state
  logic [CW-1:0]              major_pos;
  logic [CW-1:0]              major_end;
  logic signed [ACC_W-1:0]    minor_accum;
  logic signed [SLOPE_W-1:0]  slope_step;
  logic                       axes_swapped;
  logic                       slope_neg;
  logic [dlr_pkg::RGBA_W-1:0] held_rgba;

  logic                       div_done;
  logic [FRACTION_BITS:0]     div_quot;
  logic [SLOPE_W-1:0]         slope_mag;
  logic [CW-1:0]              minor;
  logic [CW-1:0]              px, py;

  // Set up the line: clamp, pick the major axis, order the endpoints
  always_comb begin
    x1        = clamp_coord(start_x);
    y1        = clamp_coord(start_y);
    x2        = clamp_coord(end_x);
    y2        = clamp_coord(end_y);
    dx        = {1'b0, x2} - {1'b0, x1};
    dy        = {1'b0, y2} - {1'b0, y1};
    abs_dx    = dx[CW] ? CW'(-dx) : dx[CW-1:0];
    abs_dy    = dy[CW] ? CW'(-dy) : dy[CW-1:0];
    steep     = abs_dy > abs_dx;
    maj1      = steep ? y1 : x1;
    min1      = steep ? x1 : y1;
    maj2      = steep ? y2 : x2;
    min2      = steep ? x2 : y2;
    abs_maj   = steep ? abs_dy : abs_dx;
    abs_min   = steep ? abs_dx : abs_dy;
    neg_slope = dx[CW] ^ dy[CW];
    reversed  = maj1 > maj2;
    maj_start = reversed ? maj2 : maj1;
    min_start = reversed ? min2 : min1;
    maj_stop  = reversed ? maj1 : maj2;
  end

  dlr_div #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.load),
    .dividend (abs_min),
    .divisor  (abs_maj),
    .done     (div_done),
    .quotient (div_quot)
  );

  assign slope_mag = {1'b0, div_quot};
  assign minor     = minor_accum[FRACTION_BITS +: CW];
  assign px        = axes_swapped ? minor : major_pos;
  assign py        = axes_swapped ? major_pos : minor;

  assign status.div_done = div_done;
  assign status.at_end   = (major_pos == major_end);
  assign status.out_free = !out_valid || !out_stall;

  // Capture the command, take the slope, step along the major axis
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      major_pos    <= maj_start;
      major_end    <= maj_stop;
      minor_accum  <= {1'b0, min_start, {FRACTION_BITS{1'b0}}};
      axes_swapped <= steep;
      slope_neg    <= neg_slope;
      held_rgba    <= line_rgba;
    end else if (cmd.emit && !status.at_end) begin
      major_pos   <= major_pos + CW'(1);
      minor_accum <= minor_accum + {{(ACC_W - SLOPE_W){slope_step[SLOPE_W-1]}}, slope_step};
    end
    if (div_done) begin
      slope_step <= slope_neg ? -slope_mag : slope_mag;
    end
  end

  // Output register: load on emit, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      pixel_x    <= px;
      pixel_y    <= py;
      pixel_rgba <= held_rgba;
      visible    <= ({1'b0, px} < raster_width) && ({1'b0, py} < raster_height);
      last_pixel <= status.at_end;
    end
  end

`ifndef NO_ASSERTIONS
  // The final pixel of a line is flagged as such
  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && status.at_end) |=> (out_valid && last_pixel))
    else $error("final pixel not flagged");
  // A pixel waiting under stall is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> status.out_free)
    else $error("pixel emitted into a full output register");
  // The minor accumulator never goes negative on a line
  a_accum_sign: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !minor_accum[ACC_W-1])
    else $error("minor accumulator negative");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/dlr_ctrl.sv
`default_nettype none

module dlr_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  output dlr_pkg::dlr_cmd_t         cmd,
  input  wire dlr_pkg::dlr_status_t status
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_DRAW
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = (state != ST_IDLE);

  // Commands and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (status.div_done) begin
          state_next = ST_DRAW;
        end
      end
      ST_DRAW: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.at_end) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef NO_ASSERTIONS
  // An accepted transaction always starts a division
  a_accept_divide: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == ST_DIVIDE))
    else $error("accepted transaction did not start a division");
  // The division result moves the controller on to drawing
  a_divide_draw: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIVIDE && status.div_done) |=> (state == ST_DRAW))
    else $error("division finished without drawing");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/dda_line_rasterizer.sv
`default_nettype none

// Channel   Direction  Handshake             Payload
// input     in         in_valid / in_stall   start_x, start_y, end_x, end_y, line_rgba
// output    out        out_valid / out_stall pixel_x, pixel_y, pixel_rgba, visible, last_pixel
// config    in         APB (psel, penable)   raster_width @ 0x0, raster_height @ 0x4
//
// A line is taken as a transaction, then the shift-subtract divider produces the slope one bit
// per cycle, then the stepper emits one pixel per cycle while the output is not stalled.
// Stalls on the output hold the pixel stepper; the next transaction is taken once the last
// pixel sits in the output register.
// rst is synchronous and active high; it clears the controller, the divider and the
// output valid, and sets both raster limits to 64.
module dda_line_rasterizer #(
  parameter int FRACTION_BITS = 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // line commands
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [dlr_pkg::COORD_W-1:0] start_x,
  input  wire logic [dlr_pkg::COORD_W-1:0] start_y,
  input  wire logic [dlr_pkg::COORD_W-1:0] end_x,
  input  wire logic [dlr_pkg::COORD_W-1:0] end_y,
  input  wire logic [dlr_pkg::RGBA_W-1:0]  line_rgba,
  // pixels
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [dlr_pkg::COORD_W-1:0]      pixel_x,
  output logic [dlr_pkg::COORD_W-1:0]      pixel_y,
  output logic [dlr_pkg::RGBA_W-1:0]       pixel_rgba,
  output logic                             visible,
  output logic                             last_pixel,
  // configuration
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [2:0]                  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  localparam int CFG_W = dlr_pkg::CFG_W;

  logic [CFG_W-1:0]     raster_width;
  logic [CFG_W-1:0]     raster_height;
  dlr_pkg::dlr_reg_t    reg_sel;
  logic                 cfg_write;
  dlr_pkg::dlr_cmd_t    cmd;
  dlr_pkg::dlr_status_t status;

  assign pready    = 1'b1;
  assign reg_sel   = dlr_pkg::dlr_reg_t'(paddr[2]);
  assign cfg_write = psel && penable && pwrite && pready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      raster_width  <= CFG_W'(dlr_pkg::TILE_SIZE);
      raster_height <= CFG_W'(dlr_pkg::TILE_SIZE);
    end else if (cfg_write) begin
      case (reg_sel)
        dlr_pkg::REG_RASTER_WIDTH:  raster_width  <= pwdata[CFG_W-1:0];
        dlr_pkg::REG_RASTER_HEIGHT: raster_height <= pwdata[CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_sel)
      dlr_pkg::REG_RASTER_WIDTH:  prdata = {{(32 - CFG_W){1'b0}}, raster_width};
      dlr_pkg::REG_RASTER_HEIGHT: prdata = {{(32 - CFG_W){1'b0}}, raster_height};
      default:                    prdata = '0;
    endcase
  end

  dlr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .status   (status)
  );

  dlr_datapath #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .raster_width  (raster_width),
    .raster_height (raster_height),
    .start_x       (start_x),
    .start_y       (start_y),
    .end_x         (end_x),
    .end_y         (end_y),
    .line_rgba     (line_rgba),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .pixel_x       (pixel_x),
    .pixel_y       (pixel_y),
    .pixel_rgba    (pixel_rgba),
    .visible       (visible),
    .last_pixel    (last_pixel)
  );

`ifndef NO_ASSERTIONS
  // No new transaction is taken while a line is still being drawn
  a_one_line: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second transaction taken during a line");
  // A raster width write lands in the register
  a_cfg_write: assert property (@(posedge clk) disable iff (rst)
    (cfg_write && reg_sel == dlr_pkg::REG_RASTER_WIDTH) |=>
      (raster_width == $past(pwdata[CFG_W-1:0])))
    else $error("raster width write lost");
`endif

endmodule

`default_nettype wire

FILE: test/tb_dda_line_rasterizer.sv
`timescale 1ns / 1ps

module tb_dda_line_rasterizer;

  localparam int FIX_SHIFT       = 8;
  localparam int CYCLE_LIMIT     = 500000;
  localparam int SETTLE_CYCLES   = 40;
  localparam int NUM_PHASES      = 6;
  localparam int LINES_PER_PHASE = 37;

  typedef struct packed {
    logic [dlr_pkg::COORD_W-1:0] x;
    logic [dlr_pkg::COORD_W-1:0] y;
    logic [dlr_pkg::RGBA_W-1:0]  rgba;
    logic                        vis;
    logic                        last;
  } pixel_t;

  // Track raster limits and the pixels still owed by accepted line commands
  class pixel_tracker;
    pixel_t     pending_pixels[$];
    int         errors;
    logic [6:0] width_limit;
    logic [6:0] height_limit;

    function new();
      errors       = 0;
      width_limit  = 7'd64;
      height_limit = 7'd64;
    endfunction

    task report(string msg);
      $display("%0t mismatch: %s", $time, msg);
      errors++;
    endtask

    function void set_limit(dlr_pkg::dlr_reg_t idx, logic [6:0] value);
      case (idx)
        dlr_pkg::REG_RASTER_WIDTH:  width_limit = value;
        dlr_pkg::REG_RASTER_HEIGHT: height_limit = value;
        default: ;
      endcase
    endfunction

    function void add_pixel(int px, int py, logic [dlr_pkg::RGBA_W-1:0] rgba, logic last);
      pixel_t p;
      p.x    = px[dlr_pkg::COORD_W-1:0];
      p.y    = py[dlr_pkg::COORD_W-1:0];
      p.rgba = rgba;
      p.vis  = (px >= 0 && px < int'(width_limit) && py >= 0 && py < int'(height_limit));
      p.last = last;
      pending_pixels.push_back(p);
    endfunction

    // Walk the line as a fixed-point DDA and queue every pixel in drawing order
    function void note_line(logic [dlr_pkg::COORD_W-1:0] sx, logic [dlr_pkg::COORD_W-1:0] sy,
                            logic [dlr_pkg::COORD_W-1:0] ex, logic [dlr_pkg::COORD_W-1:0] ey,
                            logic [dlr_pkg::RGBA_W-1:0] rgba);
      int  ax, ay, bx, by, dx, dy, tmp, slope, accum, m, minor;
      bit  steep;
      ax = int'(sx);
      ay = int'(sy);
      bx = int'(ex);
      by = int'(ey);
      if (ax == bx && ay == by) begin
        add_pixel(ax, ay, rgba, 1'b1);
        return;
      end
      dx = bx - ax;
      dy = by - ay;
      steep = ((dy < 0 ? -dy : dy) > (dx < 0 ? -dx : dx));
      // steep line: walk along y instead
      if (steep) begin
        tmp = ax; ax = ay; ay = tmp;
        tmp = bx; bx = by; by = tmp;
      end
      // make the major coordinate rise
      if (ax > bx) begin
        tmp = ax; ax = bx; bx = tmp;
        tmp = ay; ay = by; by = tmp;
      end
      dx = bx - ax;
      dy = by - ay;
      slope = (dy * (1 << FIX_SHIFT)) / dx;
      accum = ay * (1 << FIX_SHIFT);
      for (m = ax; m <= bx; m++) begin
        minor = accum >>> FIX_SHIFT;
        if (steep) add_pixel(minor, m, rgba, m == bx);
        else add_pixel(m, minor, rgba, m == bx);
        accum += slope;
      end
    endfunction

    task check_pixel(pixel_t got);
      pixel_t want;
      if (pending_pixels.size() == 0) begin
        report($sformatf("pixel (%0d,%0d) with no line pending", got.x, got.y));
        return;
      end
      want = pending_pixels.pop_front();
      if (got.x !== want.x)
        report($sformatf("pixel_x %0d, expected %0d", got.x, want.x));
      if (got.y !== want.y)
        report($sformatf("pixel_y %0d, expected %0d", got.y, want.y));
      if (got.rgba !== want.rgba)
        report($sformatf("pixel_rgba %h, expected %h", got.rgba, want.rgba));
      if (got.vis !== want.vis)
        report($sformatf("visible %b, expected %b at (%0d,%0d)",
                         got.vis, want.vis, want.x, want.y));
      if (got.last !== want.last)
        report($sformatf("last_pixel %b, expected %b at (%0d,%0d)",
                         got.last, want.last, want.x, want.y));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                         in_valid  = 1'b0;
  logic                         in_stall;
  logic [dlr_pkg::COORD_W-1:0]  start_x   = '0;
  logic [dlr_pkg::COORD_W-1:0]  start_y   = '0;
  logic [dlr_pkg::COORD_W-1:0]  end_x     = '0;
  logic [dlr_pkg::COORD_W-1:0]  end_y     = '0;
  logic [dlr_pkg::RGBA_W-1:0]   line_rgba = '0;

  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [dlr_pkg::COORD_W-1:0]  pixel_x;
  logic [dlr_pkg::COORD_W-1:0]  pixel_y;
  logic [dlr_pkg::RGBA_W-1:0]   pixel_rgba;
  logic                         visible;
  logic                         last_pixel;

  logic                         psel    = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite  = 1'b0;
  logic [2:0]                   paddr   = '0;
  logic [31:0]                  pwdata  = '0;
  logic [31:0]                  prdata;
  logic                         pready;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int cycle_count   = 0;

  pixel_tracker sb;

  dda_line_rasterizer u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .start_x    (start_x),
    .start_y    (start_y),
    .end_x      (end_x),
    .end_y      (end_y),
    .line_rgba  (line_rgba),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .pixel_rgba (pixel_rgba),
    .visible    (visible),
    .last_pixel (last_pixel),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #1 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Stall the pixel channel at random
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Check every pixel transaction
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_pixel({pixel_x, pixel_y, pixel_rgba, visible, last_pixel});
  end

  // One APB transfer: setup cycle, then access cycle until pready
  task automatic apb_access(input dlr_pkg::dlr_reg_t idx, input bit wr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    if (wr) sb.set_limit(idx, wdata[6:0]);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write a raster limit and read it back
  task automatic write_limit(input dlr_pkg::dlr_reg_t idx, input logic [6:0] value);
    logic [31:0] rd;
    apb_access(idx, 1'b1, {25'd0, value}, rd);
    apb_access(idx, 1'b0, 32'd0, rd);
    if (rd !== {25'd0, value})
      sb.report($sformatf("register %s reads %h, expected %h", idx.name(), rd, value));
  endtask

  // Offer one line command, idling at random first, and hold it until taken
  task automatic send_line(input logic [dlr_pkg::COORD_W-1:0] sx,
                           input logic [dlr_pkg::COORD_W-1:0] sy,
                           input logic [dlr_pkg::COORD_W-1:0] ex,
                           input logic [dlr_pkg::COORD_W-1:0] ey,
                           input logic [dlr_pkg::RGBA_W-1:0] rgba);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    start_x   <= sx;
    start_y   <= sy;
    end_x     <= ex;
    end_y     <= ey;
    line_rgba <= rgba;
    do @(posedge clk); while (in_stall);
    sb.note_line(sx, sy, ex, ey, rgba);
  endtask

  // Drop valid, then wait for the owed pixels and let the block settle
  task automatic drain_lines();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Random line command, biased toward short, axis-aligned, diagonal, degenerate and corner lines
  task automatic send_random_line();
    int sx, sy, ex, ey, len, kind;
    kind = $urandom_range(99);
    sx = $urandom_range(63);
    sy = $urandom_range(63);
    ex = $urandom_range(63);
    ey = $urandom_range(63);
    if (kind < 35) begin
      // fully random endpoints
    end else if (kind < 60) begin
      ex = sx + $urandom_range(12) - 6;
      ey = sy + $urandom_range(12) - 6;
      ex = ex < 0 ? 0 : (ex > 63 ? 63 : ex);
      ey = ey < 0 ? 0 : (ey > 63 ? 63 : ey);
    end else if (kind < 70) begin
      if ($urandom_range(1)) ey = sy;
      else ex = sx;
    end else if (kind < 78) begin
      // diagonal of random length and direction
      len = $urandom_range(63);
      sx = $urandom_range(63 - len);
      sy = $urandom_range(63 - len);
      ex = sx + len;
      ey = sy + len;
      if ($urandom_range(1)) begin
        sx = 63 - sx;
        ex = 63 - ex;
      end
      if ($urandom_range(1)) begin
        sy = 63 - sy;
        ey = 63 - ey;
      end
    end else if (kind < 88) begin
      ex = sx;
      ey = sy;
    end else begin
      sx = $urandom_range(1) ? 63 : 0;
      sy = $urandom_range(1) ? 63 : 0;
      ex = $urandom_range(1) ? 63 : $urandom_range(63);
      ey = $urandom_range(1) ? 0 : $urandom_range(63);
    end
    send_line(dlr_pkg::COORD_W'(sx), dlr_pkg::COORD_W'(sy),
              dlr_pkg::COORD_W'(ex), dlr_pkg::COORD_W'(ey), $urandom());
  endtask

  initial begin
    int         p, k;
    logic [6:0] w_cfg[NUM_PHASES];
    logic [6:0] h_cfg[NUM_PHASES];
    sb = new();
    w_cfg = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd64, 7'd37};
    h_cfg = '{7'd64, 7'd127, 7'd64, 7'd0, 7'd1, 7'd20};
    w_cfg[5] = 7'($urandom_range(1, 64));
    h_cfg[5] = 7'($urandom_range(1, 64));

    repeat (6) @(negedge clk);
    rst <= 1'b0;

    for (p = 0; p < NUM_PHASES; p++) begin
      // receiver-heavy stalling, then sender-heavy idling, then none
      if (p < 2) begin
        send_idle_pct = 25;
        stall_pct     = 57;
      end else if (p < 4) begin
        send_idle_pct = 57;
        stall_pct     = 25;
      end else begin
        send_idle_pct = 0;
        stall_pct     = 0;
      end

      // first phase runs on the reset limits
      if (p > 0) begin
        drain_lines();
        write_limit(dlr_pkg::REG_RASTER_WIDTH, w_cfg[p]);
        write_limit(dlr_pkg::REG_RASTER_HEIGHT, h_cfg[p]);
      end

      if (p == 0) begin
        send_line(6'd0, 6'd0, 6'd0, 6'd0, 32'h0000_0000);
        send_line(6'd63, 6'd63, 6'd63, 6'd63, 32'hFFFF_FFFF);
        send_line(6'd0, 6'd0, 6'd63, 6'd0, 32'hA5A5_A5A5);
        send_line(6'd63, 6'd63, 6'd0, 6'd63, 32'h5A5A_5A5A);
        send_line(6'd0, 6'd0, 6'd0, 6'd63, 32'h0123_4567);
        send_line(6'd5, 6'd63, 6'd0, 6'd0, 32'h89AB_CDEF);
        send_line(6'd0, 6'd0, 6'd63, 6'd63, 32'hFF00_FF00);
        send_line(6'd63, 6'd0, 6'd0, 6'd63, 32'h00FF_00FF);
        send_line(6'd0, 6'd40, 6'd63, 6'd10, 32'hDEAD_BEEF);
        send_line(6'd10, 6'd0, 6'd12, 6'd63, 32'h1234_5678);
        send_line(6'd20, 6'd20, 6'd21, 6'd20, 32'h8000_0001);
        send_line(6'd20, 6'd20, 6'd20, 6'd19, 32'h7FFF_FFFE);
        send_line(6'd30, 6'd10, 6'd10, 6'd31, 32'hCAFE_F00D);
        send_line(6'd2, 6'd1, 6'd61, 6'd3, 32'h0F0F_0F0F);
        send_line(6'd42, 6'd21, 6'd21, 6'd42, 32'hF0F0_F0F0);
      end

      for (k = 0; k < LINES_PER_PHASE; k++) send_random_line();
    end

    drain_lines();
    if (sb.pending_pixels.size() != 0)
      sb.report($sformatf("%0d pixels never arrived", sb.pending_pixels.size()));
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
